// ===== rtl/core/three_channel_square_tone_generator_core_macros.svh =====
// Assertion macros for the three-channel tone generator core.
// Used by the top level only; needs nothing else.
`ifndef THREE_CHANNEL_SQUARE_TONE_GENERATOR_CORE_MACROS_SVH
`define THREE_CHANNEL_SQUARE_TONE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define TCSTG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone generator check failed");

// Next-cycle implication, quiet while reset is asserted
`define TCSTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone generator check failed");

`endif

// ===== rtl/core/tcstg_pkg.sv =====
// Shared types and constants for the three-channel tone generator core.
// No dependencies.
`default_nettype none

package tcstg_pkg;

    localparam int NUM_CH    = 3;
    localparam int CH_W      = 2;
    localparam int PERIOD_W  = 12;
    localparam int RELOAD_W  = PERIOD_W + 1;
    localparam int CNT_W     = RELOAD_W;
    localparam int CYC_W     = 10;
    localparam int VOL_W     = 4;
    localparam int PHASE_W   = 4;
    localparam int SEL_W     = 4;
    localparam int ACC_W     = 9;
    localparam int SAMPLE_W  = 14;
    localparam int OUT_SHIFT = 5;

    // Input item kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Address decode on bits 15..13
    localparam logic [2:0] DEC_SELECT = 3'b110;
    localparam logic [2:0] DEC_DATA   = 3'b111;

    // Register select codes
    localparam logic [SEL_W-1:0] SEL_PER0_LO = 4'h0;
    localparam logic [SEL_W-1:0] SEL_PER0_HI = 4'h1;
    localparam logic [SEL_W-1:0] SEL_PER1_LO = 4'h2;
    localparam logic [SEL_W-1:0] SEL_PER1_HI = 4'h3;
    localparam logic [SEL_W-1:0] SEL_PER2_LO = 4'h4;
    localparam logic [SEL_W-1:0] SEL_PER2_HI = 4'h5;
    localparam logic [SEL_W-1:0] SEL_MIXER   = 4'h7;
    localparam logic [SEL_W-1:0] SEL_VOL0    = 4'h8;
    localparam logic [SEL_W-1:0] SEL_VOL1    = 4'h9;
    localparam logic [SEL_W-1:0] SEL_VOL2    = 4'hA;

    typedef logic [NUM_CH-1:0][PERIOD_W-1:0] period_arr_t;
    typedef logic [NUM_CH-1:0][VOL_W-1:0]    vol_arr_t;
    typedef logic [NUM_CH-1:0]               mask_t;

    typedef struct packed {
        logic                start;
        logic [CYC_W-1:0]    dividend;
        logic [RELOAD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [CYC_W-1:0]    quotient;
        logic [RELOAD_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/three_channel_square_tone_generator_core.sv =====
// Three-channel square tone generator core: bus writes and ticks in, one sample per tick.
// A tick visits each channel in turn: a masked channel is skipped, an unmasked one either
// counts down without a reload or runs the shared divider to reload, then its term is added;
// the output register is loaded last, held while the previous sample waits, and the input
// is taken again after that. Reset (rst_n low, asynchronous) clears registers and phases
// and sets every counter to one. Needs tcstg_pkg, _bus_regs, _div.
`default_nettype none
`include "three_channel_square_tone_generator_core_macros.svh"

module three_channel_square_tone_generator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [15:0] bus_address,
    input  wire logic [7:0]  bus_data,
    input  wire logic [9:0]  cycles,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [13:0] sample
);
    import tcstg_pkg::*;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_CHK  = 3'd1;
    localparam logic [STATE_W-1:0] S_DIV  = 3'd2;
    localparam logic [STATE_W-1:0] S_ACC  = 3'd3;
    localparam logic [STATE_W-1:0] S_EMIT = 3'd4;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

    typedef logic [NUM_CH-1:0][CNT_W-1:0]   cnt_arr_t;
    typedef logic [NUM_CH-1:0][PHASE_W-1:0] phase_arr_t;

    logic [STATE_W-1:0]       state_reg, state_next;
    logic [CH_W-1:0]          ch_reg, ch_next;
    logic [CYC_W-1:0]         cycles_reg, cycles_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    cnt_arr_t                 cnt_reg, cnt_next;
    phase_arr_t               phase_reg, phase_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;

    period_arr_t              period;
    vol_arr_t                 volume;
    mask_t                    disable_mask;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     wr_en;
    logic [CNT_W-1:0]         cd;
    logic [RELOAD_W-1:0]      reload;
    logic [VOL_W+1:0]         mag;
    logic signed [ACC_W-1:0]  term;

    assign in_ready = (state_reg == S_IDLE);
    assign wr_en    = in_valid && in_ready && (cmd == CMD_WRITE);

    tcstg_bus_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .bus_address  (bus_address),
        .bus_data     (bus_data),
        .period       (period),
        .volume       (volume),
        .disable_mask (disable_mask)
    );

    tcstg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Per-channel operands of the current step
    assign cd     = cnt_reg[ch_reg];
    assign reload = {period[ch_reg], 1'b1};
    assign mag    = {2'b00, volume[ch_reg]} + {1'b0, volume[ch_reg], 1'b0};
    assign term   = phase_reg[ch_reg][PHASE_W-1]
                    ? -$signed({{(ACC_W-VOL_W-2){1'b0}}, mag})
                    :  $signed({{(ACC_W-VOL_W-2){1'b0}}, mag});

    // Sequence the channels of one tick
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cycles_next    = cycles_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        div_req.start    = 1'b0;
        div_req.dividend = cycles_reg - cd[CYC_W-1:0];
        div_req.divisor  = reload;

        // Drop the held sample once transferred
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && cmd == CMD_TICK)
                begin
                    cycles_next = cycles;
                    ch_next     = '0;
                    acc_next    = '0;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                if (disable_mask[ch_reg])
                begin
                    if (ch_reg == LAST_CH)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
                else if (cd > {{(CNT_W-CYC_W){1'b0}}, cycles_reg})
                begin
                    cnt_next[ch_reg] = cd - {{(CNT_W-CYC_W){1'b0}}, cycles_reg};
                    state_next       = S_ACC;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                // Reload leaves reload minus the overshoot remainder; phase steps q+1
                if (div_rsp.done)
                begin
                    cnt_next[ch_reg]   = reload - div_rsp.remainder;
                    phase_next[ch_reg] = phase_reg[ch_reg] + div_rsp.quotient[PHASE_W-1:0]
                                         + 1'b1;
                    state_next         = S_ACC;
                end
            end
            S_ACC:
            begin
                acc_next = acc_reg + term;
                if (ch_reg == LAST_CH)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_CHK;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    sample_next    = {acc_reg, {OUT_SHIFT{1'b0}}};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                cnt_reg[i] <= CNT_W'(1);
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Working data and the output sample carry no reset
    always_ff @(posedge clk)
    begin
        cycles_reg <= cycles_next;
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Checks on the sequencer and the shared divider
    `TCSTG_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)
    `TCSTG_ASSERT_NOW(a_counters_live, clk, rst_n, 1'b1,
        cnt_reg[0] != '0 && cnt_reg[1] != '0 && cnt_reg[2] != '0)
    `TCSTG_ASSERT_NEXT(a_div_done_acc, clk, rst_n, state_reg == S_DIV && div_rsp.done,
        state_reg == S_ACC)
    `TCSTG_ASSERT_NOW(a_sample_range, clk, rst_n, out_valid,
        sample <= 14'sd4320 && sample >= -14'sd4320)

endmodule

`default_nettype wire

// ===== rtl/core/tcstg_bus_regs.sv =====
// Bus-side register file: select latch, channel periods, volumes, mixer mask.
// Depends on tcstg_pkg.
`default_nettype none

module tcstg_bus_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [15:0]           bus_address,
    input  wire logic [7:0]            bus_data,
    output tcstg_pkg::period_arr_t     period,
    output tcstg_pkg::vol_arr_t        volume,
    output tcstg_pkg::mask_t           disable_mask
);
    import tcstg_pkg::*;

    logic [SEL_W-1:0] sel_reg, sel_next;
    period_arr_t      period_reg, period_next;
    vol_arr_t         volume_reg, volume_next;
    mask_t            mask_reg, mask_next;
    logic [2:0]       dec;

    assign dec = bus_address[15:13];

    // Decode the write and update the selected register
    always_comb
    begin
        sel_next    = sel_reg;
        period_next = period_reg;
        volume_next = volume_reg;
        mask_next   = mask_reg;
        if (wr_en && dec == DEC_SELECT)
        begin
            sel_next = bus_data[SEL_W-1:0];
        end
        else if (wr_en && dec == DEC_DATA)
        begin
            unique case (sel_reg)
                SEL_PER0_LO: period_next[0][7:0]  = bus_data;
                SEL_PER0_HI: period_next[0][11:8] = bus_data[3:0];
                SEL_PER1_LO: period_next[1][7:0]  = bus_data;
                SEL_PER1_HI: period_next[1][11:8] = bus_data[3:0];
                SEL_PER2_LO: period_next[2][7:0]  = bus_data;
                SEL_PER2_HI: period_next[2][11:8] = bus_data[3:0];
                SEL_MIXER:   mask_next            = bus_data[NUM_CH-1:0];
                SEL_VOL0:    volume_next[0]       = bus_data[VOL_W-1:0];
                SEL_VOL1:    volume_next[1]       = bus_data[VOL_W-1:0];
                SEL_VOL2:    volume_next[2]       = bus_data[VOL_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= '0;
            period_reg <= '0;
            volume_reg <= '0;
            mask_reg   <= '0;
        end
        else
        begin
            sel_reg    <= sel_next;
            period_reg <= period_next;
            volume_reg <= volume_next;
            mask_reg   <= mask_next;
        end
    end

    assign period       = period_reg;
    assign volume       = volume_reg;
    assign disable_mask = mask_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tcstg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on tcstg_pkg.
`default_nettype none

module tcstg_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tcstg_pkg::div_req_t  req,
    output tcstg_pkg::div_rsp_t       rsp
);
    import tcstg_pkg::*;

    localparam int STEP_W = $clog2(CYC_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CYC_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CYC_W-1:0]    quo_reg, quo_next;
    logic [RELOAD_W-1:0] rem_reg, rem_next;
    logic [RELOAD_W-1:0] dvs_reg, dvs_next;
    logic [RELOAD_W+1:0] shifted;
    logic [RELOAD_W+1:0] trial;

    // Shift in the next dividend bit and try a subtraction
    assign shifted = {1'b0, rem_reg, quo_reg[CYC_W-1]};
    assign trial   = shifted - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[CYC_W-2:0], ~trial[RELOAD_W+1]};
            rem_next = trial[RELOAD_W+1] ? shifted[RELOAD_W-1:0] : trial[RELOAD_W-1:0];
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operands and partial results carry no reset
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire
